@@ hdl/igdm_pkg.sv @@
// Shared types, widths and helpers for the IoU greedy detection matcher.
// No dependencies; every other file imports this package.
package igdm_pkg;

   localparam int MAX_DETECTIONS = 32;
   localparam int COORD_BITS     = 12;

   localparam int IDX_W = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);

   // configuration register widths
   localparam int ATT_W      = 16;
   localparam int BOX_W      = 10;
   localparam int FRM_W      = 12;
   localparam int THR_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // item field widths
   localparam int MODE_W    = 2;
   localparam int LIFE_W    = 16;
   localparam int VERD_W    = 2;
   localparam int OUT_IDX_W = 5;
   localparam int FA_W      = 6;
   localparam int DROP_W    = 16;
   localparam int TOT_W     = 32;

   // signed arithmetic widths
   localparam int CORE_W = (COORD_BITS > FRM_W) ? COORD_BITS : FRM_W;
   localparam int SW     = CORE_W + 2;      // coordinates and spans
   localparam int PW     = 2 * SW;          // areas
   localparam int UW     = PW + 2;          // union
   localparam int XW     = PW + UW;         // cross products
   localparam int TW     = UW + THR_W + 1;  // threshold product
   localparam int DET_W  = 2 * COORD_BITS;  // one stored detection

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD      = 2'd0,
      MODE_TRUTH     = 2'd1,
      MODE_FRAME_END = 2'd2,
      MODE_NONE      = 2'd3
   } mode_type;

   typedef enum logic [VERD_W-1:0] {
      VERD_HIT       = 2'd0,
      VERD_MISS      = 2'd1,
      VERD_MISS_OUT  = 2'd2,
      VERD_FRAME_END = 2'd3
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_TIME = 3'd0,
      CSR_BOX_SIZE    = 3'd1,
      CSR_FRAME_W     = 3'd2,
      CSR_FRAME_H     = 3'd3,
      CSR_MATCH_THR   = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DECIDE,
      ST_RESOLVE,
      ST_SHIFT,
      ST_FRAME,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [SW-1:0] half;
      logic signed [SW-1:0] cols;
      logic signed [SW-1:0] rows;
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] top;
      logic signed [SW-1:0] right;
      logic signed [SW-1:0] bottom;
   } geom_type;

   typedef struct packed {
      logic                 vld;
      logic                 busy;
      logic [IDX_W-1:0]     idx;
      logic signed [PW-1:0] ia;
      logic signed [UW-1:0] ua;
   } score_type;

   function automatic logic in_margin(input logic signed [SW-1:0] x,
                                      input logic signed [SW-1:0] y,
                                      input logic signed [SW-1:0] m,
                                      input logic signed [SW-1:0] cols,
                                      input logic signed [SW-1:0] rows);
      return (x > m) && (x < cols - m) && (y > m) && (y < rows - m);
   endfunction

endpackage

@@ hdl/igdm_if.sv @@
// Valid/ready channel interfaces for the matcher request and response items.
// Depends on igdm_pkg.
interface igdm_req_if import igdm_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [COORD_BITS-1:0] track_x;
   logic [COORD_BITS-1:0] track_y;
   logic [LIFE_W-1:0]     track_lifetime;
   logic [COORD_BITS-1:0] truth_left;
   logic [COORD_BITS-1:0] truth_top;
   logic [COORD_BITS-1:0] truth_right;
   logic [COORD_BITS-1:0] truth_bottom;

   modport source (output valid, mode, track_x, track_y, track_lifetime,
                   truth_left, truth_top, truth_right, truth_bottom, input ready);
   modport sink (input valid, mode, track_x, track_y, track_lifetime,
                 truth_left, truth_top, truth_right, truth_bottom, output ready);
endinterface

interface igdm_rsp_if import igdm_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [VERD_W-1:0]    verdict;
   logic [OUT_IDX_W-1:0] match_index;
   logic [FA_W-1:0]      frame_false_alarms;
   logic [DROP_W-1:0]    dropped_tracks;
   logic [TOT_W-1:0]     hits_total;
   logic [TOT_W-1:0]     misses_total;
   logic [TOT_W-1:0]     false_alarms_total;

   modport source (output valid, verdict, match_index, frame_false_alarms,
                   dropped_tracks, hits_total, misses_total, false_alarms_total,
                   input ready);
   modport sink (input valid, verdict, match_index, frame_false_alarms,
                 dropped_tracks, hits_total, misses_total, false_alarms_total,
                 output ready);
endinterface

@@ hdl/igdm_score.sv @@
// Three-stage scoring pipe: clipped detection box, intersection and union area.
// Depends on igdm_pkg.
module igdm_score import igdm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic [IDX_W-1:0]      in_idx,
   input  logic [COORD_BITS-1:0] det_x,
   input  logic [COORD_BITS-1:0] det_y,
   input  geom_type              geom,
   input  logic signed [PW-1:0]  garea,
   output score_type             so
);

   logic signed [SW-1:0] x_s, y_s, x1, y1, x2, y2, xa, ya, xb, yb;
   logic signed [SW-1:0] lo_x, lo_y, hi_x, hi_y;
   logic signed [SW-1:0] dw_ff, dh_ff, ix_ff, iy_ff;
   logic signed [SW-1:0] dw_in, dh_in, ix_in, iy_in;
   logic signed [PW-1:0] darea_ff, ia_ff, ia2_ff;
   logic signed [UW-1:0] ua_ff;
   logic                 v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]     idx1_ff, idx2_ff, idx3_ff;

   always_comb begin
      x_s  = $signed({{(SW-COORD_BITS){1'b0}}, det_x});
      y_s  = $signed({{(SW-COORD_BITS){1'b0}}, det_y});
      xa   = x_s - geom.half;
      ya   = y_s - geom.half;
      xb   = x_s + geom.half;
      yb   = y_s + geom.half;
      x1   = (xa > 0) ? xa : '0;
      y1   = (ya > 0) ? ya : '0;
      x2   = (xb < geom.cols) ? xb : geom.cols;
      y2   = (yb < geom.rows) ? yb : geom.rows;
      hi_x = (geom.right < x2) ? geom.right : x2;
      hi_y = (geom.bottom < y2) ? geom.bottom : y2;
      lo_x = (geom.left > x1) ? geom.left : x1;
      lo_y = (geom.top > y1) ? geom.top : y1;
      dw_in = x2 - x1;
      dh_in = y2 - y1;
      ix_in = hi_x - lo_x;
      iy_in = hi_y - lo_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      // clip and span
      dw_ff   <= dw_in;
      dh_ff   <= dh_in;
      ix_ff   <= ix_in;
      iy_ff   <= iy_in;
      idx1_ff <= in_idx;
      // areas
      darea_ff <= dw_ff * dh_ff;
      ia_ff    <= (ix_ff > 0 && iy_ff > 0) ? ix_ff * iy_ff : '0;
      idx2_ff  <= idx1_ff;
      // union
      ua_ff   <= UW'(garea) + UW'(darea_ff) - UW'(ia_ff);
      ia2_ff  <= ia_ff;
      idx3_ff <= idx2_ff;
   end

   assign so.vld  = v3_ff;
   assign so.busy = v1_ff | v2_ff | v3_ff;
   assign so.idx  = idx3_ff;
   assign so.ia   = ia2_ff;
   assign so.ua   = ua_ff;

endmodule

@@ hdl/iou_greedy_detection_matcher.sv @@
// Load track: no response. Truth box: detection RAM reads are paced by the best-score loop so that
// each compare closes before the next candidate; a hit adds a compaction pass over the store.
// Frame end: one RAM read a cycle. One item in flight; a finished response waits in an output
// register while the next item is taken. Synchronous active-high reset restores register defaults,
// empties the store and zeroes all totals.
module iou_greedy_detection_matcher import igdm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   igdm_req_if.sink              req_ch,
   igdm_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------- configuration
   logic [ATT_W-1:0] att_ff;
   logic [BOX_W-1:0] box_ff;
   logic [FRM_W-1:0] fw_ff, fh_ff;
   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_ff <= ATT_W'(5);
         box_ff <= BOX_W'(64);
         fw_ff  <= FRM_W'(640);
         fh_ff  <= FRM_W'(480);
         thr_ff <= THR_W'(128);
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_ACTIVE_TIME: att_ff <= csr_wdata[ATT_W-1:0];
            CSR_BOX_SIZE:    box_ff <= csr_wdata[BOX_W-1:0];
            CSR_FRAME_W:     fw_ff  <= csr_wdata[FRM_W-1:0];
            CSR_FRAME_H:     fh_ff  <= csr_wdata[FRM_W-1:0];
            CSR_MATCH_THR:   thr_ff <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff;
   logic [DROP_W-1:0]       dropped_ff;
   logic [TOT_W-1:0]        hits_ff, miss_ff, fa_ff;
   logic [COORD_BITS-1:0]   tl_ff, tt_ff, tr_ff, tb_ff;
   logic signed [PW-1:0]    garea_ff;

   // scan
   logic [CNT_W-1:0]        issue_ff;
   logic                    phase_ff, tok_ff, issue_now, scan_done;
   logic [IDX_W-1:0]        tok_idx_ff;
   score_type               so;
   logic                    m_vld_ff;
   logic signed [XW-1:0]    p1_ff, p2_ff;
   logic signed [PW-1:0]    m_ia_ff, best_i_ff;
   logic signed [UW-1:0]    m_ua_ff, best_u_ff;
   logic [IDX_W-1:0]        m_idx_ff, best_k_ff;

   // decide
   logic signed [TW-1:0]    thp_ff, bi_sh;
   logic signed [SW-1:0]    cx_ff, cy_ff, cx_in, cy_in, sum_x, sum_y, dif_x, dif_y;
   logic                    hit;

   // compaction and frame walk
   logic [CNT_W-1:0]        sh_rd_ff, fr_rd_ff, fa_n_ff;
   logic                    sh_pend_ff, fr_pend_ff, sh_done, fr_done;
   logic [IDX_W-1:0]        sh_wr_ff;
   logic [TOT_W:0]          fa_sum;

   // result
   logic [VERD_W-1:0]       res_verd_ff;
   logic [OUT_IDX_W-1:0]    res_idx_ff;
   logic [FA_W-1:0]         res_fa_ff;
   logic [DROP_W-1:0]       res_drop_ff;
   logic                    rsp_valid_ff, rsp_free;

   // detection RAM
   logic [DET_W-1:0]        det_mem [MAX_DETECTIONS];
   logic [DET_W-1:0]        mem_rdata_ff, mem_wdata;
   logic [IDX_W-1:0]        mem_raddr, mem_waddr;
   logic                    mem_we;

   geom_type                geom;
   logic signed [SW-1:0]    margin_s, rd_x, rd_y;
   logic                    req_acc, load_ok, store_full;
   mode_type                mode;

   // ---------------------------------------------------------------- decode
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign mode         = mode_type'(req_ch.mode);
   assign store_full   = !(count_ff < CNT_W'(MAX_DETECTIONS));
   assign load_ok      = req_acc && (mode == MODE_LOAD) && (req_ch.track_lifetime > att_ff);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      geom.half   = $signed({{(SW-BOX_W+1){1'b0}}, box_ff[BOX_W-1:1]});
      geom.cols   = $signed({{(SW-FRM_W){1'b0}}, fw_ff});
      geom.rows   = $signed({{(SW-FRM_W){1'b0}}, fh_ff});
      geom.left   = $signed({{(SW-COORD_BITS){1'b0}}, tl_ff});
      geom.top    = $signed({{(SW-COORD_BITS){1'b0}}, tt_ff});
      geom.right  = $signed({{(SW-COORD_BITS){1'b0}}, tr_ff});
      geom.bottom = $signed({{(SW-COORD_BITS){1'b0}}, tb_ff});
      margin_s    = $signed({{(SW-BOX_W+2){1'b0}}, box_ff[BOX_W-1:2]});
      rd_x = $signed({{(SW-COORD_BITS){1'b0}}, mem_rdata_ff[DET_W-1:COORD_BITS]});
      rd_y = $signed({{(SW-COORD_BITS){1'b0}}, mem_rdata_ff[COORD_BITS-1:0]});
   end

   // ---------------------------------------------------------------- detection RAM
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      if (load_ok && !store_full) begin
         // append a qualifying track at the end of the store
         mem_we    = 1'b1;
         mem_waddr = count_ff[IDX_W-1:0];
         mem_wdata = {req_ch.track_x, req_ch.track_y};
      end else if (state_ff == ST_SHIFT && sh_pend_ff) begin
         // move one entry down over the removed one
         mem_we    = 1'b1;
         mem_waddr = sh_wr_ff;
         mem_wdata = mem_rdata_ff;
      end
      case (state_ff)
         ST_SCAN:  mem_raddr = issue_ff[IDX_W-1:0];
         ST_SHIFT: mem_raddr = sh_rd_ff[IDX_W-1:0];
         ST_FRAME: mem_raddr = fr_rd_ff[IDX_W-1:0];
         default:  mem_raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         det_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= det_mem[mem_raddr];
   end

   // ---------------------------------------------------------------- scoring
   // Pause after each issued read so the best-score compare closes before the
   // next candidate reaches the cross-multiply stage.
   assign issue_now = (state_ff == ST_SCAN) && !phase_ff && (issue_ff < count_ff);
   assign scan_done = (issue_ff == count_ff) && !tok_ff && !so.busy && !m_vld_ff;

   igdm_score u_score (
      .clock  (clock),
      .reset  (reset),
      .in_vld (tok_ff),
      .in_idx (tok_idx_ff),
      .det_x  (mem_rdata_ff[DET_W-1:COORD_BITS]),
      .det_y  (mem_rdata_ff[COORD_BITS-1:0]),
      .geom   (geom),
      .garea  (garea_ff),
      .so     (so)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= 1'b0;
         phase_ff <= 1'b0;
         m_vld_ff <= 1'b0;
      end else begin
         tok_ff   <= issue_now;
         phase_ff <= issue_now;
         m_vld_ff <= so.vld;
      end
   end

   always_ff @(posedge clock) begin
      tok_idx_ff <= issue_ff[IDX_W-1:0];
      // cross-multiply against the running best
      p1_ff    <= so.ia * best_u_ff;
      p2_ff    <= best_i_ff * so.ua;
      m_ia_ff  <= so.ia;
      m_ua_ff  <= so.ua;
      m_idx_ff <= so.idx;
      if (state_ff == ST_IDLE) begin
         issue_ff  <= '0;
         best_i_ff <= '0;
         best_u_ff <= UW'(1);
         best_k_ff <= '0;
      end else begin
         if (issue_now) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         // earliest strictly better score wins
         if (m_vld_ff && m_ia_ff > 0 && p1_ff > p2_ff) begin
            best_i_ff <= m_ia_ff;
            best_u_ff <= m_ua_ff;
            best_k_ff <= m_idx_ff;
         end
      end
      if (state_ff == ST_PREP) begin
         garea_ff <= (geom.right - geom.left) * (geom.bottom - geom.top);
      end
   end

   // ---------------------------------------------------------------- decide
   always_comb begin
      sum_x = geom.left + geom.half;
      sum_y = geom.top + geom.half;
      dif_x = geom.right - geom.half;
      dif_y = geom.bottom - geom.half;
      if (tl_ff != '0 && tt_ff != '0) begin
         cx_in = (sum_x < geom.cols) ? sum_x : geom.cols;
         cy_in = (sum_y < geom.rows) ? sum_y : geom.rows;
      end else begin
         cx_in = (dif_x > 0) ? dif_x : '0;
         cy_in = (dif_y > 0) ? dif_y : '0;
      end
      bi_sh = TW'(best_i_ff) <<< 8;
      hit   = (count_ff != '0) && !(bi_sh < thp_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         thp_ff <= $signed({1'b0, thr_ff}) * best_u_ff;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
   end

   // ---------------------------------------------------------------- compaction / frame walk
   assign sh_done = (sh_rd_ff == count_ff) && !sh_pend_ff;
   assign fr_done = (fr_rd_ff == count_ff) && !fr_pend_ff;
   assign fa_sum  = {1'b0, fa_ff} + (TOT_W+1)'(fa_n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_pend_ff <= 1'b0;
         fr_pend_ff <= 1'b0;
      end else begin
         sh_pend_ff <= (state_ff == ST_SHIFT) && (sh_rd_ff < count_ff);
         fr_pend_ff <= (state_ff == ST_FRAME) && (fr_rd_ff < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESOLVE) begin
         sh_rd_ff <= CNT_W'(best_k_ff) + CNT_W'(1);
      end else if (state_ff == ST_SHIFT && sh_rd_ff < count_ff) begin
         sh_rd_ff <= sh_rd_ff + CNT_W'(1);
         sh_wr_ff <= sh_rd_ff[IDX_W-1:0] - IDX_W'(1);
      end
      if (state_ff == ST_IDLE) begin
         fr_rd_ff <= '0;
         fa_n_ff  <= '0;
      end else if (state_ff == ST_FRAME) begin
         if (fr_rd_ff < count_ff) begin
            fr_rd_ff <= fr_rd_ff + CNT_W'(1);
         end
         if (fr_pend_ff && in_margin(rd_x, rd_y, margin_s, geom.cols, geom.rows)) begin
            fa_n_ff <= fa_n_ff + CNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- FSM
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (mode)
                  MODE_TRUTH:     state_in = ST_PREP;
                  MODE_FRAME_END: state_in = ST_FRAME;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_PREP:    state_in = ST_SCAN;
         ST_SCAN:    if (scan_done) state_in = ST_DECIDE;
         ST_DECIDE:  state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = hit ? ST_SHIFT : ST_EMIT;
         ST_SHIFT:   if (sh_done) state_in = ST_EMIT;
         ST_FRAME:   if (fr_done) state_in = ST_EMIT;
         ST_EMIT:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- store count and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= '0;
         hits_ff    <= '0;
         miss_ff    <= '0;
         fa_ff      <= '0;
      end else begin
         if (load_ok) begin
            if (!store_full) begin
               count_ff <= count_ff + CNT_W'(1);
            end else if (dropped_ff != '1) begin
               dropped_ff <= dropped_ff + DROP_W'(1);
            end
         end
         if (state_ff == ST_RESOLVE) begin
            if (hit) begin
               if (hits_ff != '1) hits_ff <= hits_ff + TOT_W'(1);
            end else if (in_margin(cx_ff, cy_ff, margin_s, geom.cols, geom.rows)) begin
               if (miss_ff != '1) miss_ff <= miss_ff + TOT_W'(1);
            end
         end
         if (state_ff == ST_SHIFT && sh_done) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (state_ff == ST_FRAME && fr_done) begin
            // fold the frame's false alarms into the saturating total, drop the store and the refused-track tally
            fa_ff      <= fa_sum[TOT_W] ? '1 : fa_sum[TOT_W-1:0];
            count_ff   <= '0;
            dropped_ff <= '0;
         end
      end
   end

   // ---------------------------------------------------------------- result fields
   always_ff @(posedge clock) begin
      if (state_ff == ST_RESOLVE) begin
         res_fa_ff   <= '0;
         res_drop_ff <= dropped_ff;
         if (hit) begin
            res_verd_ff <= VERD_HIT;
            res_idx_ff  <= OUT_IDX_W'(best_k_ff);
         end else begin
            res_verd_ff <= in_margin(cx_ff, cy_ff, margin_s, geom.cols, geom.rows)
                           ? VERD_MISS : VERD_MISS_OUT;
            res_idx_ff  <= '0;
         end
      end else if (state_ff == ST_FRAME && fr_done) begin
         res_verd_ff <= VERD_FRAME_END;
         res_idx_ff  <= '0;
         res_fa_ff   <= FA_W'(fa_n_ff);
         res_drop_ff <= dropped_ff;
      end
      if (state_ff == ST_IDLE && req_acc) begin
         tl_ff <= req_ch.truth_left;
         tt_ff <= req_ch.truth_top;
         tr_ff <= req_ch.truth_right;
         tb_ff <= req_ch.truth_bottom;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_ch.verdict            <= res_verd_ff;
         rsp_ch.match_index        <= res_idx_ff;
         rsp_ch.frame_false_alarms <= res_fa_ff;
         rsp_ch.dropped_tracks     <= res_drop_ff;
         rsp_ch.hits_total         <= hits_ff;
         rsp_ch.misses_total       <= miss_ff;
         rsp_ch.false_alarms_total <= fa_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

endmodule

@@ hdl/igdm_checker.sv @@
// Port-level checks for the matcher response channel, bound to the top level.
// Depends on igdm_pkg and iou_greedy_detection_matcher.
module igdm_checker import igdm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VERD_W-1:0]    rsp_verdict,
   input logic [OUT_IDX_W-1:0] rsp_match_index,
   input logic [FA_W-1:0]      rsp_frame_false_alarms,
   input logic [TOT_W-1:0]     rsp_hits_total
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("stalled response item changed");

   a_fa_only_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERD_FRAME_END |-> rsp_frame_false_alarms == '0)
      else $error("false alarms reported outside frame end");

   a_index_only_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERD_HIT |-> rsp_match_index == '0)
      else $error("match index reported without a hit");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERD_HIT |-> rsp_hits_total != '0)
      else $error("hit reported with zero hit total");

endmodule

bind iou_greedy_detection_matcher igdm_checker u_igdm_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_ch.valid),
   .rsp_ready              (rsp_ch.ready),
   .rsp_verdict            (rsp_ch.verdict),
   .rsp_match_index        (rsp_ch.match_index),
   .rsp_frame_false_alarms (rsp_ch.frame_false_alarms),
   .rsp_hits_total         (rsp_ch.hits_total)
);
